[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the power sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lps_pkg.sv]
// ----------------------------------------------------------------------------
// Lamp power sequencer package
// Types, codes and constants shared by the sequencer files.
// ----------------------------------------------------------------------------
package lps_pkg;

    // soft-start steps; the top level is one above this
    localparam int unsigned LPS_RAMP_STEPS = 64;
    localparam logic [6:0]  LPS_RAMP_TOP   = 7'(LPS_RAMP_STEPS + 1);

    localparam int unsigned LPS_CFG_W    = 16;
    localparam int unsigned LPS_CFG_IDX_W = 3;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_SET12 = 3'd1,
        OP_SET24 = 3'd2,
        OP_LAMP  = 3'd3,
        OP_EDGE  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_REJECTED = 2'd1,
        ST_NO_12V   = 2'd2,
        ST_BUSY     = 2'd3
    } t_status;

    typedef enum logic [LPS_CFG_IDX_W-1:0] {
        CFG_ON_LOW     = 3'd0,
        CFG_ON_HIGH    = 3'd1,
        CFG_FAULT_LOW  = 3'd2,
        CFG_FAULT_HIGH = 3'd3,
        CFG_WARMUP     = 3'd4,
        CFG_FREQ_WIN   = 3'd5,
        CFG_RAMP_UP    = 3'd6,
        CFG_RAMP_DOWN  = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_UP   = 3'b010,
        PH_DOWN = 3'b100
    } t_ramp_phase;

    typedef struct packed {
        logic [2:0]  op;
        logic        on;
        logic [7:0]  dim;
        logic [15:0] voltage_mv;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  rail12_level;
        logic        rail12_on;
        logic        rail24_on;
        logic        lamp_enable;
        logic [6:0]  lamp_pwm;
        logic [15:0] lamp_hz;
        logic        fault;
    } t_out_item;

endpackage

[rtl/lps_in_if.sv]
// ----------------------------------------------------------------------------
// Sequencer input channel
// Valid/ready channel carrying one tick, command or status edge.
// ----------------------------------------------------------------------------
interface lps_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic        on;
    logic [7:0]  dim;
    logic [15:0] voltage_mv;

    modport source (output valid, output op, output on, output dim, output voltage_mv,
                    input ready);
    modport sink   (input valid, input op, input on, input dim, input voltage_mv,
                    output ready);
endinterface

[rtl/lps_out_if.sv]
// ----------------------------------------------------------------------------
// Sequencer result channel
// Valid/ready channel carrying one result per input transaction.
// ----------------------------------------------------------------------------
interface lps_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [6:0]  rail12_level;
    logic        rail12_on;
    logic        rail24_on;
    logic        lamp_enable;
    logic [6:0]  lamp_pwm;
    logic [15:0] lamp_hz;
    logic        fault;

    modport source (output valid, output status, output rail12_level, output rail12_on,
                    output rail24_on, output lamp_enable, output lamp_pwm,
                    output lamp_hz, output fault, input ready);
    modport sink   (input valid, input status, input rail12_level, input rail12_on,
                    input rail24_on, input lamp_enable, input lamp_pwm,
                    input lamp_hz, input fault, output ready);
endinterface

[rtl/lamp_power_sequencer_core.sv]
// ----------------------------------------------------------------------------
// Lamp power sequencer core
// Sequences the 12V soft-start, 24V enable and lamp drive, and measures the
// lamp status edge rate.
// ----------------------------------------------------------------------------
// The core takes one transaction per clock on i_in (a 1 ms tick, a 12V, 24V
// or lamp command, or a lamp status edge) unless o_out stalls, and returns
// exactly one result per transaction on o_out, in order. Sustained rate is
// one transaction per cycle while o_out accepts results. A transaction passes
// through the input register and then the result register; while o_out
// stalls, both hold. Commands (12V, 24V, lamp) arriving while a soft-start
// ramp runs answer busy and change nothing; the ramp only moves on ticks.
// The user writes thresholds and timings on the cfg port only while the core
// is idle; the core itself does not enforce this.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lamp_power_sequencer_core
    import lps_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    lps_in_if.sink                   i_in,
    lps_out_if.source                o_out,
    input  logic                     i_cfg_we,
    input  logic [LPS_CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [LPS_CFG_W-1:0]     i_cfg_data
);

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [15:0] r_on_low, r_on_high, r_fault_low, r_fault_high;
    logic [15:0] r_warmup, r_freq_win;
    logic [7:0]  r_ramp_up, r_ramp_down;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_low     <= 16'd11500;
            r_on_high    <= 16'd12500;
            r_fault_low  <= 16'd10500;
            r_fault_high <= 16'd13500;
            r_warmup     <= 16'd5000;
            r_freq_win   <= 16'd1000;
            r_ramp_up    <= 8'd8;
            r_ramp_down  <= 8'd1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ON_LOW:     r_on_low     <= i_cfg_data;
                CFG_ON_HIGH:    r_on_high    <= i_cfg_data;
                CFG_FAULT_LOW:  r_fault_low  <= i_cfg_data;
                CFG_FAULT_HIGH: r_fault_high <= i_cfg_data;
                CFG_WARMUP:     r_warmup     <= i_cfg_data;
                CFG_FREQ_WIN:   r_freq_win   <= i_cfg_data;
                CFG_RAMP_UP:    r_ramp_up    <= i_cfg_data[7:0];
                CFG_RAMP_DOWN:  r_ramp_down  <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Pipeline handshake: input register feeds the result register. The
    // input side keeps taking transactions while the result register can
    // be refilled in the same cycle.
    // ---------------------------------------------------------------------
    logic      r_s1_valid;
    t_in_item  r_s1;
    logic      r_out_valid;
    t_out_item r_out;
    logic      out_free;
    logic      s1_adv;

    assign out_free   = !r_out_valid || o_out.ready;
    assign s1_adv     = r_s1_valid && out_free;
    assign i_in.ready = !r_s1_valid || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1.op         <= i_in.op;
            r_s1.on         <= i_in.on;
            r_s1.dim        <= i_in.dim;
            r_s1.voltage_mv <= i_in.voltage_mv;
        end
    end

    // ---------------------------------------------------------------------
    // Sequencer state
    // ---------------------------------------------------------------------
    t_ramp_phase r_phase,     n_phase;
    logic [6:0]  r_level,     n_level;
    logic [7:0]  r_prescale,  n_prescale;
    logic        r_rail12,    n_rail12;
    logic        r_rail24,    n_rail24;
    logic        r_lamp,      n_lamp;
    logic [6:0]  r_dim,       n_dim;
    logic [15:0] r_lamp_age,  n_lamp_age;
    logic [15:0] r_win_cnt,   n_win_cnt;
    logic [15:0] r_edge_cnt,  n_edge_cnt;
    logic [15:0] r_freq,      n_freq;

    logic [7:0]  step_sel;
    logic [7:0]  step_per;
    logic        busy;
    logic        v_fault;
    logic        v_on_bad;
    t_status     res_status;
    logic        res_fault;

    // zero ticks per step behaves as one
    assign step_sel = (r_phase == PH_UP) ? r_ramp_up : r_ramp_down;
    assign step_per = (step_sel == 8'd0) ? 8'd1 : step_sel;
    assign busy     = (r_phase != PH_IDLE);
    assign v_fault  = (r_s1.voltage_mv < r_fault_low) || (r_s1.voltage_mv > r_fault_high);
    assign v_on_bad = (r_s1.voltage_mv < r_on_low) || (r_s1.voltage_mv > r_on_high);

    always_comb begin
        n_phase    = r_phase;
        n_level    = r_level;
        n_prescale = r_prescale;
        n_rail12   = r_rail12;
        n_rail24   = r_rail24;
        n_lamp     = r_lamp;
        n_dim      = r_dim;
        n_lamp_age = r_lamp_age;
        n_win_cnt  = r_win_cnt;
        n_edge_cnt = r_edge_cnt;
        n_freq     = r_freq;
        res_status = ST_OK;
        res_fault  = 1'b0;

        case (t_op'(r_s1.op))
            OP_TICK: begin
                // ramp advance
                if (busy) begin
                    n_prescale = r_prescale + 8'd1;
                    if (n_prescale >= step_per) begin
                        n_prescale = '0;
                        if (r_phase == PH_UP) begin
                            if (r_level >= LPS_RAMP_TOP) begin
                                n_phase  = PH_IDLE;
                                n_rail12 = 1'b1;
                            end else begin
                                n_level = r_level + 7'd1;
                            end
                        end else begin
                            if (r_level == 7'd0) begin
                                n_phase  = PH_IDLE;
                                n_rail12 = 1'b0;
                            end else begin
                                n_level = r_level - 7'd1;
                            end
                        end
                    end
                end
                // frequency window
                if (r_win_cnt >= r_freq_win) begin
                    n_freq     = r_edge_cnt;
                    n_edge_cnt = '0;
                    n_win_cnt  = '0;
                end else begin
                    n_win_cnt = r_win_cnt + 16'd1;
                end
                if (r_lamp_age != 16'hFFFF) begin
                    n_lamp_age = r_lamp_age + 16'd1;
                end
                // supply out of the fault window: lamp and 24V off, 12V ramps down
                if (v_fault) begin
                    res_fault  = 1'b1;
                    n_lamp     = 1'b0;
                    n_dim      = '0;
                    n_lamp_age = '0;
                    n_rail24   = 1'b0;
                    if (n_phase == PH_UP || (n_phase == PH_IDLE && n_rail12)) begin
                        n_phase    = PH_DOWN;
                        n_prescale = '0;
                    end
                end
            end
            OP_EDGE: begin
                if (r_edge_cnt != 16'hFFFF) begin
                    n_edge_cnt = r_edge_cnt + 16'd1;
                end
            end
            OP_SET12: begin
                if (busy) begin
                    res_status = ST_BUSY;
                end else if (r_s1.on && v_on_bad) begin
                    res_status = ST_REJECTED;
                end else if (r_s1.on && !r_rail12) begin
                    n_level    = '0;
                    n_phase    = PH_UP;
                    n_prescale = '0;
                end else if (!r_s1.on && r_rail12) begin
                    n_level    = LPS_RAMP_TOP;
                    n_phase    = PH_DOWN;
                    n_prescale = '0;
                end
            end
            OP_SET24: begin
                if (busy) begin
                    res_status = ST_BUSY;
                end else if (r_s1.on && !r_rail12) begin
                    res_status = ST_REJECTED;
                end else begin
                    n_rail24 = r_s1.on;
                end
            end
            OP_LAMP: begin
                if (busy) begin
                    res_status = ST_BUSY;
                end else begin
                    n_dim      = (r_s1.dim > 8'd100) ? 7'd100 : r_s1.dim[6:0];
                    n_lamp     = r_s1.on;
                    n_lamp_age = '0;
                    if (r_s1.on && !r_rail12) begin
                        res_status = ST_NO_12V;
                    end
                end
            end
            default: begin
                res_status = ST_REJECTED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_level    <= '0;
            r_prescale <= '0;
            r_rail12   <= 1'b0;
            r_rail24   <= 1'b0;
            r_lamp     <= 1'b0;
            r_dim      <= 7'd100;
            r_lamp_age <= '0;
            r_win_cnt  <= '0;
            r_edge_cnt <= '0;
            r_freq     <= '0;
        end else if (s1_adv) begin
            r_phase    <= n_phase;
            r_level    <= n_level;
            r_prescale <= n_prescale;
            r_rail12   <= n_rail12;
            r_rail24   <= n_rail24;
            r_lamp     <= n_lamp;
            r_dim      <= n_dim;
            r_lamp_age <= n_lamp_age;
            r_win_cnt  <= n_win_cnt;
            r_edge_cnt <= n_edge_cnt;
            r_freq     <= n_freq;
        end
    end

    // ---------------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out.status       <= res_status;
            r_out.rail12_level <= n_level;
            r_out.rail12_on    <= n_rail12;
            r_out.rail24_on    <= n_rail24;
            r_out.lamp_enable  <= n_lamp;
            // full power (0) during warm-up
            r_out.lamp_pwm     <= (n_lamp_age < r_warmup) ? 7'd0 : n_dim;
            r_out.lamp_hz      <= n_freq;
            r_out.fault        <= res_fault;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out.status;
    assign o_out.rail12_level = r_out.rail12_level;
    assign o_out.rail12_on    = r_out.rail12_on;
    assign o_out.rail24_on    = r_out.rail24_on;
    assign o_out.lamp_enable  = r_out.lamp_enable;
    assign o_out.lamp_pwm     = r_out.lamp_pwm;
    assign o_out.lamp_hz      = r_out.lamp_hz;
    assign o_out.fault        = r_out.fault;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    `LPS_ASSERT_NOW(a_up_rail_off, i_clk, i_rst_n, r_phase == PH_UP, !r_rail12,
        "12V flagged on during up ramp")
    `LPS_ASSERT_NOW(a_idle_prescale, i_clk, i_rst_n, r_phase == PH_IDLE,
        r_prescale == 8'd0, "ramp prescaler not cleared while idle")
    `LPS_ASSERT_NEXT(a_s1_held, i_clk, i_rst_n, r_s1_valid && !out_free, r_s1_valid,
        "stalled transaction lost from input register")
    `LPS_ASSERT_NOW(a_fault_off, i_clk, i_rst_n, r_out_valid && r_out.fault,
        !r_out.lamp_enable && !r_out.rail24_on, "fault result with lamp or 24V on")

endmodule
